// ===== hw/rtl/mnep_pkg.sv =====
// Shared types and constants for the MIDI note event parser.
// No dependencies; every other file imports this package.
package mnep_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned KeyW = 7;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [TimeoutW-1:0] IDLE_MAX = 16'hFFFF;

  localparam logic [7:0] NOTE_LOW = 8'd21;
  localparam logic [7:0] NOTE_HIGH = 8'd108;

  // status kinds (upper nibble)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;
  localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESSURE = 4'hD;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic hit;
    logic key_released;
    logic [KeyW-1:0] key_index;
  } note_evt_t;

endpackage

// ===== hw/rtl/mnep_if.sv =====
// Valid/ready channel interfaces for the MIDI note event parser.
// Depends on mnep_pkg for field widths.
interface mnep_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [7:0] rx_byte;
  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface mnep_out_if import mnep_pkg::*;;
  logic valid;
  logic ready;
  logic key_released;
  logic [KeyW-1:0] key_index;
  modport source (output valid, output key_released, output key_index, input ready);
  modport sink (input valid, input key_released, input key_index, output ready);
endinterface

interface mnep_cfg_if import mnep_pkg::*;;
  logic valid;
  logic ready;
  logic [TimeoutW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mnep_parser.sv =====
// Parser state (phase, held bytes, idle counter) and the per-item decode.
// Depends on mnep_pkg. The event output is combinational from the current item.
module mnep_parser import mnep_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                action,
  input  logic [7:0]          rx_byte,
  input  logic [TimeoutW-1:0] timeout_ticks,
  output note_evt_t           evt
);

  phase_t              phase, phase_next;
  logic [7:0]          held_status, held_status_next;
  logic [7:0]          held_first_data, held_first_data_next;
  logic [TimeoutW-1:0] idle_count, idle_count_next;

  phase_t     ph_eff;
  logic [7:0] st_eff;
  logic [7:0] fd_eff;
  logic       expired;
  logic [7:0] note;
  logic [7:0] velocity;
  logic       note_msg;

  // a byte after a long idle first drops any partial message
  assign expired = idle_count > timeout_ticks;
  assign ph_eff = expired ? PH_STATUS : phase;
  assign st_eff = expired ? 8'h00 : held_status;
  assign fd_eff = expired ? 8'h00 : held_first_data;

  always_comb begin
    phase_next = phase;
    held_status_next = held_status;
    held_first_data_next = held_first_data;
    idle_count_next = idle_count;
    note_msg = 1'b0;
    if (action == ACT_TICK) begin
      if (idle_count != IDLE_MAX) begin
        idle_count_next = idle_count + 1'b1;
      end
    end else begin
      idle_count_next = '0;
      held_status_next = st_eff;
      held_first_data_next = fd_eff;
      case (ph_eff)
        PH_DATA1: begin
          held_first_data_next = rx_byte;
          if (st_eff[7:4] inside {KIND_PROG_CHANGE, KIND_CHAN_PRESSURE}) begin
            phase_next = PH_STATUS;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          note_msg = 1'b1;
          phase_next = PH_STATUS;
        end
        default: begin
          phase_next = PH_STATUS;
          if (rx_byte[7]) begin
            held_status_next = rx_byte;
            phase_next = PH_DATA1;
          end
        end
      endcase
    end
  end

  assign note = fd_eff;
  assign velocity = rx_byte;

  always_comb begin
    evt = '0;
    evt.key_index = KeyW'(note - NOTE_LOW);
    if (note_msg && note inside {[NOTE_LOW:NOTE_HIGH]}) begin
      case (st_eff[7:4])
        KIND_NOTE_ON: begin
          evt.hit = 1'b1;
          evt.key_released = (velocity == 8'h00);
        end
        KIND_NOTE_OFF: begin
          evt.hit = 1'b1;
          evt.key_released = 1'b1;
        end
        default: evt.hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STATUS;
      held_status <= '0;
      held_first_data <= '0;
      idle_count <= '0;
    end else if (step) begin
      phase <= phase_next;
      held_status <= held_status_next;
      held_first_data <= held_first_data_next;
      idle_count <= idle_count_next;
    end
  end

endmodule

// ===== hw/rtl/mnep_out_stage.sv =====
// Result register driving the outgoing key event channel.
// Depends on mnep_pkg and mnep_out_if.
module mnep_out_stage import mnep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  note_evt_t evt,
  output logic      free,
  mnep_out_if.source result
);

  logic            valid;
  logic            key_released;
  logic [KeyW-1:0] key_index;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_released <= evt.key_released;
      key_index <= evt.key_index;
    end
  end

  assign result.valid = valid;
  assign result.key_released = key_released;
  assign result.key_index = key_index;

endmodule

// ===== hw/rtl/midi_note_event_parser.sv =====
// MIDI note event parser: top level with input register and timeout register.
// Depends on mnep_pkg, mnep_if, mnep_parser and mnep_out_stage.
//
// Channels: item (action, rx_byte) in, result (key_released, key_index) out,
// cfg writes the 16-bit timeout in milliseconds; cfg is always ready.
// An item is a millisecond tick (action 0) or a received MIDI byte (action 1).
// Each completed note-on/note-off for notes 21..108 yields one key event;
// every other item yields nothing.
// A request accepted into the input register is decoded there and, if it
// makes an event, is loaded into the result register that drives result.
// Throughput: one request per cycle unless the stall below holds it; the
// parser state updates as a request leaves the input register.
// Stall: when result holds an event that is not taken, an input request that
// makes another event waits in the input register and item.ready drops;
// requests that make no event keep moving.
// Reset: parser back to waiting for status, idle count zero, timeout 100,
// both registers empty.
module midi_note_event_parser import mnep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mnep_in_if.sink    item,
  mnep_out_if.source result,
  mnep_cfg_if.sink   cfg
);

  logic                s1_valid;
  logic                s1_action;
  logic [7:0]          s1_byte;
  logic [TimeoutW-1:0] timeout_ticks;
  note_evt_t           evt;
  logic                out_free;
  logic                s1_adv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.data;
    end
  end

  assign s1_adv = s1_valid && (!evt.hit || out_free);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_action <= item.action;
      s1_byte <= item.rx_byte;
    end
  end

  mnep_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_adv),
    .action        (s1_action),
    .rx_byte       (s1_byte),
    .timeout_ticks (timeout_ticks),
    .evt           (evt)
  );

  mnep_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_adv && evt.hit),
    .evt    (evt),
    .free   (out_free),
    .result (result)
  );

  // input only backs up behind an unaccepted event
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && result.valid && !result.ready))
    else $error("input stalled without a blocked result");

  a_ticks_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_action == ACT_TICK) |-> !evt.hit)
    else $error("tick produced an event");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    evt.hit |-> (evt.key_index <= KeyW'(NOTE_HIGH - NOTE_LOW)))
    else $error("key index out of range");

  a_event_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && evt.hit) |=> result.valid)
    else $error("event lost on its way to the result register");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!result.valid && item.ready))
    else $error("registers not empty after reset");

endmodule

// ===== dv/key_event_check.sv =====
`timescale 1ns / 100ps
// Key event predictor and comparator for the MIDI note event parser bench.
// Depends on mnep_pkg and the mnep_if channel interfaces; instantiated by tb_top.
module key_event_check import mnep_pkg::*; (
  input  logic clk,
  input  logic rst,
  mnep_in_if   item,
  mnep_out_if  result,
  mnep_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  // predicted parser state
  phase_t              phase;
  logic [7:0]          status_byte;
  logic [7:0]          data1;
  logic [TimeoutW-1:0] idle_ms;
  logic [TimeoutW-1:0] idle_limit;

  note_evt_t key_events_due[$];
  int        errs = 0;

  function automatic note_evt_t parse_item(input logic act, input logic [7:0] b);
    note_evt_t  evt;
    logic [3:0] kind;
    evt = '0;
    if (act == ACT_TICK) begin
      if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 1'b1;
      return evt;
    end
    // a partial message left idle too long is dropped before this byte
    if (idle_ms > idle_limit) begin
      phase = PH_STATUS;
      status_byte = '0;
      data1 = '0;
    end
    idle_ms = '0;
    kind = status_byte[7:4];
    case (phase)
      PH_DATA1: begin
        data1 = b;
        if (kind inside {KIND_PROG_CHANGE, KIND_CHAN_PRESSURE}) phase = PH_STATUS;
        else phase = PH_DATA2;
      end
      PH_DATA2: begin
        if (data1 inside {[NOTE_LOW:NOTE_HIGH]} &&
            kind inside {KIND_NOTE_ON, KIND_NOTE_OFF}) begin
          evt.hit = 1'b1;
          evt.key_released = (kind == KIND_NOTE_OFF) || (b == 8'h00);
          evt.key_index = KeyW'(data1 - NOTE_LOW);
        end
        phase = PH_STATUS;
      end
      default: begin
        // stray data bytes are dropped; the unused phase code acts as idle
        if (b[7]) begin
          status_byte = b;
          phase = PH_DATA1;
        end else begin
          phase = PH_STATUS;
        end
      end
    endcase
    return evt;
  endfunction

  always @(posedge clk) begin : watch
    note_evt_t evt;
    note_evt_t want;
    if (rst) begin
      phase = PH_STATUS;
      status_byte = '0;
      data1 = '0;
      idle_ms = '0;
      idle_limit = TIMEOUT_RESET;
      key_events_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) idle_limit = cfg.data;
      // compare before queuing: a result never belongs to a request of the same edge
      if (result.valid && result.ready) begin
        if (key_events_due.size() == 0) begin
          $error("unexpected key event: key_released %0d key_index %0d",
                 result.key_released, result.key_index);
          errs++;
        end else begin
          want = key_events_due.pop_front();
          if (result.key_released !== want.key_released) begin
            $error("key_released: expected %0d, actual %0d",
                   want.key_released, result.key_released);
            errs++;
          end
          if (result.key_index !== want.key_index) begin
            $error("key_index: expected %0d, actual %0d", want.key_index, result.key_index);
            errs++;
          end
        end
      end
      if (item.valid && item.ready) begin
        evt = parse_item(item.action, item.rx_byte);
        if (evt.hit) key_events_due.push_back(evt);
      end
    end
    fail_count <= errs;
    pending <= key_events_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Bench top for midi_note_event_parser: reset, byte/tick stimulus, timeout writes,
// output back-pressure and the verdict. Depends on mnep_pkg, mnep_if, key_event_check.
module tb_top import mnep_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mnep_in_if  item_ch ();
  mnep_out_if result_ch ();
  mnep_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int items_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  bit quiet_tx = 1'b0;
  logic [TimeoutW-1:0] cur_timeout = TIMEOUT_RESET;

  midi_note_event_parser u_dut (
    .clk,
    .rst,
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  key_event_check u_check (
    .clk,
    .rst,
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .fail_count,
    .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_tx) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // valid stays up between back-to-back requests
  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(ACT_TICK, 8'($urandom));
  endtask

  // tick runs, some landing right at the timeout boundary
  task automatic maybe_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return;
    if (r < 93 || cur_timeout > 120) send_ticks($urandom_range(1, 4));
    else send_ticks($urandom_range(cur_timeout, cur_timeout + 1));
  endtask

  task automatic send_note(input logic [7:0] st, input logic [7:0] note,
                           input logic [7:0] vel);
    send_item(ACT_BYTE, st);
    maybe_ticks();
    send_item(ACT_BYTE, note);
    maybe_ticks();
    send_item(ACT_BYTE, vel);
  endtask

  task automatic send_message();
    int r;
    logic [7:0] st;
    logic [7:0] note;
    logic [7:0] vel;
    r = $urandom_range(0, 99);
    maybe_ticks();
    if (r < 70) begin
      st = {($urandom_range(0, 9) < 7) ? KIND_NOTE_ON : KIND_NOTE_OFF, 4'($urandom)};
      note = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(NOTE_LOW, NOTE_HIGH))
                                          : 8'($urandom);
      vel = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
      send_note(st, note, vel);
    end else if (r < 82) begin
      st = 8'($urandom_range(8'h80, 8'hFF));
      send_item(ACT_BYTE, st);
      maybe_ticks();
      send_item(ACT_BYTE, 8'($urandom));
      if (st[7:4] != KIND_PROG_CHANGE && st[7:4] != KIND_CHAN_PRESSURE)
        send_item(ACT_BYTE, 8'($urandom));
    end else if (r < 92) begin
      send_item(1'($urandom), 8'($urandom));
    end else begin
      // truncated message, left for the next status or the timeout
      send_item(ACT_BYTE, {1'b1, 7'($urandom)});
      if ($urandom_range(0, 1) == 1) send_item(ACT_BYTE, 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TimeoutW-1:0] t);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= t;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_timeout = t;
  endtask

  task automatic run_phase(input logic [TimeoutW-1:0] t, input int n);
    int start;
    wait_idle();
    write_timeout(t);
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 19) == 0) quiet_tx = !quiet_tx;
      send_message();
    end
    quiet_tx = 1'b0;
  endtask

  // result side: random stalls, long open stretches, and requested hold-offs
  initial begin : result_side
    int left;
    bit lvl;
    result_ch.ready = 1'b0;
    left = 0;
    lvl = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        lvl = 1'b0;
        left = 0;
        result_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        if (left == 0) begin
          lvl = !lvl;
          if (!lvl) left = stall_run();
          else if ($urandom_range(0, 9) == 0) left = $urandom_range(100, 300);
          else left = $urandom_range(1, 20);
          result_ch.ready <= lvl;
        end
        left--;
      end
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = ACT_TICK;
    item_ch.rx_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    write_timeout(16'd2);
    send_item(ACT_BYTE, 8'h45);
    send_note({KIND_NOTE_ON, 4'h0}, NOTE_LOW, 8'h7F);
    send_note({KIND_NOTE_ON, 4'hF}, NOTE_HIGH, 8'h00);
    send_note({KIND_NOTE_OFF, 4'hA}, NOTE_LOW - 8'd1, 8'h40);
    send_item(ACT_BYTE, {KIND_PROG_CHANGE, 4'h3});
    send_item(ACT_BYTE, 8'h30);
    send_item(ACT_BYTE, {KIND_CHAN_PRESSURE, 4'h0});
    send_item(ACT_BYTE, 8'hFF);
    send_note({KIND_NOTE_ON, 4'h0}, 8'hE0, 8'h10);
    send_note(8'hB0, 8'h40, 8'h40);
    send_item(ACT_BYTE, {KIND_NOTE_ON, 4'h5});
    send_item(ACT_BYTE, 8'h40);
    send_ticks(3);
    send_item(ACT_BYTE, 8'h50);
    send_note({KIND_NOTE_OFF, 4'h1}, NOTE_HIGH + 8'd1, 8'h00);

    run_phase(16'd1, 195);
    run_phase(16'd4, 195);

    // long output hold-off while the input keeps offering key events
    hold_requests++;
    quiet_tx = 1'b1;
    repeat (30)
      send_note({KIND_NOTE_ON, 4'($urandom)}, 8'($urandom_range(NOTE_LOW, NOTE_HIGH)),
                8'($urandom_range(1, 127)));
    quiet_tx = 1'b0;

    run_phase(TIMEOUT_RESET, 195);
    run_phase(IDLE_MAX, 195);
    run_phase(16'($urandom_range(2, 40)), 195);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
